// ===== rtl/ira_pkg.sv =====
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types, constants and helpers for the radix-to-ASCII converter.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int VALUE_BITS_DEFAULT = 31;

  localparam int              RADIX_W     = 6;
  localparam int              CHAR_W      = 7;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;
  localparam logic [CHAR_W-1:0]  NUMERAL_BASE = 7'd48;
  localparam logic [CHAR_W-1:0]  LETTER_BASE  = 7'd65;

  // controller to datapath
  typedef struct packed {
    logic load;   // take a new value and the clamped radix
    logic shift;  // one restoring division step
    logic store;  // write the remainder as a digit
    logic rd;     // register the next digit from the store
    logic pop;    // digit transferred, step down the count
  } ira_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;   // this is the final division step
    logic quo_zero;   // quotient is zero, no more digits
    logic last;       // digit on the output is the least significant one
  } ira_status_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = NUMERAL_BASE + {1'b0, d};
    end else begin
      res = LETTER_BASE + {1'b0, d - DEC_DIGITS};
    end
    return res;
  endfunction

endpackage

// ===== rtl/ira_ctrl.sv =====
// ----------------------------------------------------------------------------
// ira_ctrl
// Sequencer: division of the value digit by digit, then readout of the
// stored digits most significant first.
// ----------------------------------------------------------------------------
module ira_ctrl
  import ira_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output ira_cmd_t    cmd,
  input  ira_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_STORE = 5'b00100,
    S_READ  = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);

  always_comb begin
    cmd.load  = (state == S_IDLE) && in_valid;
    cmd.shift = (state == S_DIV);
    cmd.store = (state == S_STORE);
    cmd.rd    = (state == S_READ);
    cmd.pop   = (state == S_SEND) && out_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) state_next = S_STORE;
      end
      S_STORE: begin
        // quotient left in the dividend register decides if more digits follow
        state_next = status.quo_zero ? S_READ : S_DIV;
      end
      S_READ: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_ready) state_next = status.last ? S_IDLE : S_READ;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/ira_datapath.sv =====
// ----------------------------------------------------------------------------
// ira_datapath
// Radix register, bit-serial restoring divider, digit store and ASCII mapping.
// ----------------------------------------------------------------------------
module ira_datapath
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RADIX_W-1:0]    cfg_wdata,
  input  logic [VALUE_BITS-1:0] value,
  input  ira_cmd_t              cmd,
  output ira_status_t           status,
  output logic [CHAR_W-1:0]     digit_char
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int BIT_W = $clog2(VALUE_BITS);

  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    base;
  logic [VALUE_BITS-1:0] dividend;
  logic [RADIX_W-1:0]    rem;
  logic [BIT_W-1:0]      bit_cnt;
  logic [CNT_W-1:0]      cnt;
  logic [RADIX_W-1:0]    rd_digit;
  logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];

  logic [RADIX_W:0]      trial;
  logic                  ge;
  logic [RADIX_W:0]      diff;
  logic [CNT_W-1:0]      cnt_dec;

  // one quotient bit per cycle, remainder stays below the base
  assign trial   = {rem, dividend[VALUE_BITS-1]};
  assign ge      = (trial >= {1'b0, base});
  assign diff    = trial - {1'b0, base};
  assign cnt_dec = cnt - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base     <= clamp_radix(radix);
      dividend <= value;
      rem      <= '0;
      bit_cnt  <= '0;
      cnt      <= '0;
    end else if (cmd.shift) begin
      dividend <= {dividend[VALUE_BITS-2:0], ge};
      rem      <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      bit_cnt  <= bit_cnt + BIT_W'(1);
    end else if (cmd.store) begin
      rem     <= '0;
      bit_cnt <= '0;
      cnt     <= cnt + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt <= cnt_dec;
    end
  end

  // digits go in least significant first and come out in reverse
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      digit_mem[cnt[IDX_W-1:0]] <= rem;
    end
    if (cmd.rd) begin
      rd_digit <= digit_mem[cnt_dec[IDX_W-1:0]];
    end
  end

  always_comb begin
    status.div_done = (bit_cnt == BIT_W'(VALUE_BITS - 1));
    status.quo_zero = (dividend == '0);
    status.last     = (cnt == CNT_W'(1));
  end

  assign digit_char = digit_to_ascii(rd_digit);

endmodule

// ===== rtl/integer_to_radix_ascii_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_unit
// Converts a non-negative integer into ASCII digits in a programmable base,
// most significant digit first, flagging the final digit of each run.
// ----------------------------------------------------------------------------
//
//   port group  dir  handshake            payload
//   cfg         in   cfg_we               cfg_wdata (radix, 6 bits)
//   in          in   in_valid/in_ready    value
//   out         out  out_valid/out_ready  digit_char, last_digit
//
// Each digit is produced by the bit-serial divider and then written to the
// digit store; at readout each digit is registered from the store and then
// presented, held through any wait on out_ready. The unit converts one value
// at a time.
// Synchronous reset returns to idle and sets the radix to ten.
// A stalled output holds digit_char and last_digit until the transfer.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_unit
  import ira_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [RADIX_W-1:0]    cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     digit_char,
  output logic                  last_digit
);

  ira_cmd_t    cmd;
  ira_status_t status;

  ira_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  ira_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .value      (value),
    .cmd        (cmd),
    .status     (status),
    .digit_char (digit_char)
  );

  assign last_digit = status.last;

  // input and output sides never open together
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a digit is on the output");

  // a new value always goes through the divider before any digit shows
  a_no_early_digit: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("digit presented right after input transfer");

  // the final digit transfer frees the unit for the next value
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_digit) |=> in_ready)
    else $error("unit not idle after last digit transfer");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((digit_char >= 7'd48 && digit_char <= 7'd57) ||
                   (digit_char >= 7'd65 && digit_char <= 7'd90)))
    else $error("digit character out of range");

endmodule
